/* rtl/core/rtbmp_pkg.sv */
// shared types, constants and helpers for the recurrence term block
// depends on nothing; imported by rtbmp_modmul, the top level and the testbench
`timescale 1ns / 1ps
`default_nettype none

package rtbmp_pkg;

   localparam int WORD_W                = 30;
   localparam int TERM_INDEX_W          = 32;
   localparam int DEFAULT_EXPONENT_BITS = 32;
   localparam int MAT_SIZE              = 9;

   typedef logic [WORD_W-1:0] word_type;

   localparam word_type PRIME = 30'd1000000007;

   // barrett constant floor(2^60 / prime), fits in 31 bits
   localparam logic [30:0] BARRETT_MU = 31'((64'd1 << 60) / 64'd1000000007);

   localparam logic [3:0] LAST_ELEM  = 4'd8;
   localparam logic [1:0] LAST_INNER = 2'd2;
   localparam logic [1:0] LAST_ROW   = 2'd2;
   localparam logic [1:0] LAST_COL   = 2'd2;

   localparam word_type IDENT_MATRIX [MAT_SIZE] = '{
      30'd1, 30'd0, 30'd0,
      30'd0, 30'd1, 30'd0,
      30'd0, 30'd0, 30'd1
   };

   localparam word_type TRANS_MATRIX [MAT_SIZE] = '{
      30'd1, 30'd0, 30'd1,
      30'd1, 30'd0, 30'd0,
      30'd0, 30'd1, 30'd0
   };

   typedef struct packed {
      logic [3:0] elem;
      logic [1:0] inner;
   } term_tag_type;

   // row-major position of a 3x3 entry
   function automatic logic [3:0] mat_index(input logic [1:0] row, input logic [1:0] col);
      logic [3:0] r4;
      r4 = {2'b00, row};
      return (r4 << 1) + r4 + {2'b00, col};
   endfunction

   // sum of two residues, reduced once
   function automatic word_type mod_add(input word_type a, input word_type b);
      logic [WORD_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, PRIME}) begin
         s = s - {1'b0, PRIME};
      end
      return s[WORD_W-1:0];
   endfunction

endpackage

`default_nettype wire

/* rtl/core/recurrence_term_by_matrix_power.sv */
// term n of a(n)=a(n-1)+a(n-3) mod 1000000007 by 3x3 matrix power, depends on rtbmp_pkg and rtbmp_modmul
// walks EXPONENT_BITS bits of n-1, capped at 32; for each bit a multiply when it is set, then a square
// each matrix product issues 27 terms into the shared five-stage modular multiplier,
//   one a cycle; one request at a time, the next taken once the result is staged
// synchronous active-high reset returns the sequencer to idle and drops the result valid
`timescale 1ns / 1ps
`default_nettype none

module recurrence_term_by_matrix_power #(
   parameter int EXPONENT_BITS = rtbmp_pkg::DEFAULT_EXPONENT_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [rtbmp_pkg::TERM_INDEX_W-1:0]  req_term_index,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [rtbmp_pkg::WORD_W-1:0]        rsp_term_value
);
   import rtbmp_pkg::*;

   localparam int LOOP_BITS = (EXPONENT_BITS < TERM_INDEX_W) ? EXPONENT_BITS : TERM_INDEX_W;
   localparam int CNT_W     = $clog2(LOOP_BITS + 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SETUP  = 3'd1;
   localparam logic [2:0] ST_ISSUE  = 3'd2;
   localparam logic [2:0] ST_WAIT   = 3'd3;
   localparam logic [2:0] ST_COMMIT = 3'd4;
   localparam logic [2:0] ST_SUM1   = 3'd5;
   localparam logic [2:0] ST_SUM2   = 3'd6;

   localparam logic OP_SQR = 1'b0;
   localparam logic OP_MUL = 1'b1;

   logic [2:0]           state_ff, state_in;
   logic                 op_ff, op_in;
   logic [LOOP_BITS-1:0] exp_ff, exp_in;
   logic [CNT_W-1:0]     bit_cnt_ff, bit_cnt_in;
   logic [1:0]           row_ff, row_in;
   logic [1:0]           col_ff, col_in;
   logic [1:0]           inner_ff, inner_in;

   word_type acc_ff    [MAT_SIZE];
   word_type acc_in    [MAT_SIZE];
   word_type base_a_ff [MAT_SIZE];
   word_type base_a_in [MAT_SIZE];
   word_type base_b_ff [MAT_SIZE];
   word_type base_b_in [MAT_SIZE];
   word_type tmp_ff    [MAT_SIZE];
   word_type tmp_in    [MAT_SIZE];

   word_type     sum_ff, sum_in;
   word_type     fin_ff, fin_in;
   logic         issue_valid_ff, issue_valid_in;
   word_type     op_a_ff, op_a_in;
   word_type     op_b_ff, op_b_in;
   term_tag_type issue_tag_ff, issue_tag_in;
   logic         rsp_valid_ff, rsp_valid_in;
   word_type     rsp_value_ff, rsp_value_in;

   logic                    mm_valid;
   word_type                mm_value;
   term_tag_type            mm_tag;
   logic [TERM_INDEX_W-1:0] idx_m1;
   logic [3:0]              lhs_idx, rhs_idx;
   logic                    last_term;
   logic                    out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign idx_m1    = req_term_index - TERM_INDEX_W'(1);
   assign lhs_idx   = mat_index(row_ff, inner_ff);
   assign rhs_idx   = mat_index(inner_ff, col_ff);
   assign last_term = (row_ff == LAST_ROW) && (col_ff == LAST_COL) && (inner_ff == LAST_INNER);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   rtbmp_modmul u_modmul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (issue_valid_ff),
      .in_a      (op_a_ff),
      .in_b      (op_b_ff),
      .in_tag    (issue_tag_ff),
      .out_valid (mm_valid),
      .out_value (mm_value),
      .out_tag   (mm_tag)
   );

   // sequencer
   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      exp_in         = exp_ff;
      bit_cnt_in     = bit_cnt_ff;
      row_in         = row_ff;
      col_in         = col_ff;
      inner_in       = inner_ff;
      acc_in         = acc_ff;
      base_a_in      = base_a_ff;
      base_b_in      = base_b_ff;
      fin_in         = fin_ff;
      issue_valid_in = 1'b0;
      op_a_in        = op_a_ff;
      op_b_in        = op_b_ff;
      issue_tag_in   = issue_tag_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_value_in   = rsp_value_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               exp_in     = idx_m1[LOOP_BITS-1:0];
               bit_cnt_in = '0;
               acc_in     = IDENT_MATRIX;
               base_a_in  = TRANS_MATRIX;
               base_b_in  = TRANS_MATRIX;
               state_in   = ST_SETUP;
            end
         end
         ST_SETUP: begin
            if (bit_cnt_ff == CNT_W'(LOOP_BITS)) begin
               state_in = ST_SUM1;
            end else begin
               op_in    = exp_ff[0] ? OP_MUL : OP_SQR;
               row_in   = '0;
               col_in   = '0;
               inner_in = '0;
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            issue_valid_in     = 1'b1;
            op_a_in            = (op_ff == OP_MUL) ? acc_ff[lhs_idx] : base_a_ff[lhs_idx];
            op_b_in            = base_b_ff[rhs_idx];
            issue_tag_in.elem  = mat_index(row_ff, col_ff);
            issue_tag_in.inner = inner_ff;
            if (inner_ff == LAST_INNER) begin
               inner_in = '0;
               if (col_ff == LAST_COL) begin
                  col_in = '0;
                  row_in = row_ff + 2'd1;
               end else begin
                  col_in = col_ff + 2'd1;
               end
            end else begin
               inner_in = inner_ff + 2'd1;
            end
            if (last_term) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (mm_valid && (mm_tag.elem == LAST_ELEM) && (mm_tag.inner == LAST_INNER)) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            row_in   = '0;
            col_in   = '0;
            inner_in = '0;
            if (op_ff == OP_MUL) begin
               acc_in   = tmp_ff;
               op_in    = OP_SQR;
               state_in = ST_ISSUE;
            end else begin
               base_a_in  = tmp_ff;
               base_b_in  = tmp_ff;
               exp_in     = exp_ff >> 1;
               bit_cnt_in = bit_cnt_ff + CNT_W'(1);
               state_in   = ST_SETUP;
            end
         end
         ST_SUM1: begin
            fin_in   = mod_add(acc_ff[6], acc_ff[7]);
            state_in = ST_SUM2;
         end
         ST_SUM2: begin
            if (out_free) begin
               rsp_value_in = mod_add(fin_ff, acc_ff[8]);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // dot-product accumulation of multiplier results
   always_comb begin
      sum_in = sum_ff;
      tmp_in = tmp_ff;
      if (mm_valid) begin
         sum_in = (mm_tag.inner == 2'd0) ? mm_value : mod_add(sum_ff, mm_value);
         if (mm_tag.inner == LAST_INNER) begin
            tmp_in[mm_tag.elem] = sum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         issue_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         issue_valid_ff <= issue_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      op_ff        <= op_in;
      exp_ff       <= exp_in;
      bit_cnt_ff   <= bit_cnt_in;
      row_ff       <= row_in;
      col_ff       <= col_in;
      inner_ff     <= inner_in;
      acc_ff       <= acc_in;
      base_a_ff    <= base_a_in;
      base_b_ff    <= base_b_in;
      tmp_ff       <= tmp_in;
      sum_ff       <= sum_in;
      fin_ff       <= fin_in;
      op_a_ff      <= op_a_in;
      op_b_ff      <= op_b_in;
      issue_tag_ff <= issue_tag_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_term_value = rsp_value_ff;

`ifndef SYNTHESIS
   a_results_in_product: assert property (@(posedge clock) disable iff (reset)
      mm_valid |-> ((state_ff == ST_ISSUE) || (state_ff == ST_WAIT)))
      else $error("multiplier result outside a matrix product");

   a_commit_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMMIT) |-> (!issue_valid_ff && !mm_valid))
      else $error("matrix committed with terms still in flight");

   a_result_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_term_value < PRIME))
      else $error("term value not reduced");

   a_bit_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (bit_cnt_ff <= CNT_W'(LOOP_BITS)))
      else $error("exponent bit count overran");
`endif

endmodule

`default_nettype wire

/* rtl/core/rtbmp_modmul.sv */
// pipelined modular multiplier, product reduced by barrett estimate and two corrections
// depends on rtbmp_pkg; takes one new pair per cycle
`timescale 1ns / 1ps
`default_nettype none

module rtbmp_modmul (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  rtbmp_pkg::word_type    in_a,
   input  rtbmp_pkg::word_type    in_b,
   input  rtbmp_pkg::term_tag_type in_tag,
   output logic                   out_valid,
   output rtbmp_pkg::word_type    out_value,
   output rtbmp_pkg::term_tag_type out_tag
);
   import rtbmp_pkg::*;

   logic         valid1_ff, valid2_ff, valid3_ff, valid4_ff, valid5_ff;
   term_tag_type tag1_ff, tag2_ff, tag3_ff, tag4_ff, tag5_ff;

   logic [2*WORD_W-1:0] prod_ff, prod_in;
   logic [61:0]         quot_full;
   logic [30:0]         quot_ff, quot_in;
   logic [31:0]         low_ff, low_in;
   logic [31:0]         qp_lo;
   logic [31:0]         rem_ff, rem_in;
   logic [30:0]         red1_ff, red1_in;
   word_type            red2_ff, red2_in;

   // full product
   assign prod_in = 60'(in_a) * 60'(in_b);

   // quotient estimate, at most two below the true quotient
   assign quot_full = 62'(prod_ff[59:29]) * 62'(BARRETT_MU);
   assign quot_in   = quot_full[61:31];
   assign low_in    = prod_ff[31:0];

   // remainder below three times the prime, so 32 bits suffice
   assign qp_lo  = 32'(quot_ff) * 32'(PRIME);
   assign rem_in = low_ff - qp_lo;

   // two conditional subtractions
   assign red1_in = (rem_ff >= 32'(PRIME)) ? 31'(rem_ff - 32'(PRIME)) : rem_ff[30:0];
   assign red2_in = (red1_ff >= 31'(PRIME)) ? 30'(red1_ff - 31'(PRIME)) : red1_ff[29:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
         valid4_ff <= 1'b0;
         valid5_ff <= 1'b0;
      end else begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
         valid3_ff <= valid2_ff;
         valid4_ff <= valid3_ff;
         valid5_ff <= valid4_ff;
      end
      tag1_ff <= in_tag;
      tag2_ff <= tag1_ff;
      tag3_ff <= tag2_ff;
      tag4_ff <= tag3_ff;
      tag5_ff <= tag4_ff;
      prod_ff <= prod_in;
      quot_ff <= quot_in;
      low_ff  <= low_in;
      rem_ff  <= rem_in;
      red1_ff <= red1_in;
      red2_ff <= red2_in;
   end

   assign out_valid = valid5_ff;
   assign out_value = red2_ff;
   assign out_tag   = tag5_ff;

`ifndef SYNTHESIS
   a_residue_range: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (out_value < PRIME))
      else $error("modmul residue not below the prime");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> $past(in_valid, 5))
      else $error("modmul result without matching operands");

   a_first_fix: assert property (@(posedge clock) disable iff (reset)
      valid4_ff |-> ({1'b0, red1_ff} < (32'(PRIME) << 1)))
      else $error("modmul barrett estimate off by more than two");
`endif

endmodule

`default_nettype wire

/* dv/tb_recurrence_term_by_matrix_power.sv */
// testbench for recurrence_term_by_matrix_power: random and directed term indexes,
// each result checked against a matrix-power prediction of a(n) mod 1000000007
// depends on rtbmp_pkg and the recurrence_term_by_matrix_power rtl
`timescale 1ns / 1ps

module tb_recurrence_term_by_matrix_power;

   import rtbmp_pkg::*;

   localparam int TERM_EXPONENT_BITS = DEFAULT_EXPONENT_BITS;
   localparam logic [63:0] TERM_MODULUS = 64'd1000000007;
   localparam int QUIET_LIMIT = 40000;
   localparam int HOLDOFF_CYCLES = 8000;
   localparam int DRAIN_CYCLES = 2300;
   localparam int RANDOM_ITEMS = 300;

   typedef word_type [0:8] term_matrix_type;

   typedef struct packed {
      logic [TERM_INDEX_W-1:0] term_index;
      word_type                term_value;
   } term_expect_type;

   localparam term_matrix_type UNIT_MATRIX = {
      30'd1, 30'd0, 30'd0,
      30'd0, 30'd1, 30'd0,
      30'd0, 30'd0, 30'd1
   };
   localparam term_matrix_type STEP_MATRIX = {
      30'd1, 30'd0, 30'd1,
      30'd1, 30'd0, 30'd0,
      30'd0, 30'd1, 30'd0
   };

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [TERM_INDEX_W-1:0] req_term_index = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b1;
   logic [WORD_W-1:0]       rsp_term_value;

   term_expect_type expected_terms[$];
   int  error_count = 0;
   int  quiet_cycles = 0;
   int  receiver_holdoff = 0;
   bit  sender_idles = 1'b1;
   bit  receiver_idles = 1'b1;

   recurrence_term_by_matrix_power #(
      .EXPONENT_BITS(TERM_EXPONENT_BITS)
   ) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_term_index (req_term_index),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_term_value (rsp_term_value)
   );

   always #10 clock = ~clock;

   // 3x3 product, every multiply-accumulate reduced mod the prime
   function automatic term_matrix_type mat_product(input term_matrix_type lhs,
                                                   input term_matrix_type rhs);
      term_matrix_type prod;
      logic [63:0] acc;
      int r, c, k;
      for (r = 0; r < 3; r++) begin
         for (c = 0; c < 3; c++) begin
            acc = 64'd0;
            for (k = 0; k < 3; k++) begin
               acc = (acc + (64'(lhs[r*3+k]) * 64'(rhs[k*3+c])) % TERM_MODULUS)
                     % TERM_MODULUS;
            end
            prod[r*3+c] = acc[WORD_W-1:0];
         end
      end
      return prod;
   endfunction

   function automatic word_type predict_term(input logic [TERM_INDEX_W-1:0] term_index);
      logic [31:0] exponent;
      term_matrix_type power, base;
      logic [63:0] sum;
      int walked, pos;
      exponent = term_index - 32'd1;
      power = UNIT_MATRIX;
      base = STEP_MATRIX;
      walked = (TERM_EXPONENT_BITS < 32) ? TERM_EXPONENT_BITS : 32;
      for (pos = 0; pos < walked; pos++) begin
         if (exponent[0]) begin
            power = mat_product(power, base);
         end
         base = mat_product(base, base);
         exponent = exponent >> 1;
      end
      sum = (64'(power[6]) + 64'(power[7])) % TERM_MODULUS;
      sum = (sum + 64'(power[8])) % TERM_MODULUS;
      return sum[WORD_W-1:0];
   endfunction

   // called at a rising edge; returns at the edge where the request is taken
   task automatic send_term_request(input logic [TERM_INDEX_W-1:0] term_index);
      int gap;
      gap = sender_idles ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_term_index <= term_index;
      do @(negedge clock); while (req_stall);
      @(posedge clock);
      expected_terms.push_back('{term_index: term_index,
                                 term_value: predict_term(term_index)});
   endtask

   function automatic logic [31:0] random_term_index();
      logic [31:0] pick;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: pick = $urandom;
         5, 6:          pick = $urandom_range(0, 100);
         7:             pick = (32'd1 << $urandom_range(0, 31)) | (32'd1 << $urandom_range(0, 31));
         8:             pick = ~(32'd1 << $urandom_range(0, 31));
         default:       pick = (32'd1 << $urandom_range(0, 31)) + 32'd1;
      endcase
      return pick;
   endfunction

   // result side: stall per result, long hold-off on request, check each result
   initial begin : term_receiver
      int wait_cycles;
      term_expect_type want;
      word_type got;
      while (reset) @(posedge clock);
      forever begin
         if (receiver_holdoff > 0) begin
            wait_cycles = receiver_holdoff;
            receiver_holdoff = 0;
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            wait_cycles = receiver_idles ? $urandom_range(0, 9) : 0;
            if (wait_cycles > 0) begin
               rsp_stall <= 1'b1;
               do @(negedge clock); while (!rsp_valid);
               repeat (wait_cycles) @(posedge clock);
            end
            rsp_stall <= 1'b0;
         end
         do @(negedge clock); while (!(rsp_valid && !rsp_stall));
         got = rsp_term_value;
         @(posedge clock);
         if (expected_terms.size() == 0) begin
            $display("%0t: term_value %0d returned with no request pending", $time, got);
            error_count++;
         end else begin
            want = expected_terms.pop_front();
            if (got !== want.term_value) begin
               $display("%0t: term_value mismatch for index %0d: expected %0d, actual %0d",
                        $time, want.term_index, want.term_value, got);
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles with no handshake on either side
   always @(negedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // first terms of the sequence, including the three start values
   task automatic test_sequence_start();
      int n;
      for (n = 1; n <= 8; n++) begin
         send_term_request(32'(n));
      end
   endtask

   // index zero wraps the exponent, plus all-ones, top-bit and alternating patterns
   task automatic test_index_extremes();
      send_term_request(32'h0000_0000);
      send_term_request(32'hFFFF_FFFF);
      send_term_request(32'hFFFF_FFFE);
      send_term_request(32'h8000_0000);
      send_term_request(32'h8000_0001);
      send_term_request(32'h7FFF_FFFF);
      send_term_request(32'hAAAA_AAAA);
      send_term_request(32'h5555_5555);
      send_term_request(32'h0000_0100);
      send_term_request(32'h0100_0000);
   endtask

   // result side held off while requests keep coming, so the input stalls
   task automatic test_output_holdoff();
      int n;
      sender_idles = 1'b0;
      receiver_holdoff = HOLDOFF_CYCLES;
      for (n = 0; n < 5; n++) begin
         send_term_request(random_term_index());
      end
      sender_idles = 1'b1;
   endtask

   task automatic test_random_indexes();
      int n;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         // a stretch with no idling on either side
         sender_idles = !(n >= 150 && n < 200);
         receiver_idles = !(n >= 150 && n < 200);
         send_term_request(random_term_index());
      end
      sender_idles = 1'b1;
      receiver_idles = 1'b1;
   endtask

   initial begin : test_sequence
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_sequence_start();
      test_index_extremes();
      test_output_holdoff();
      test_random_indexes();
      req_valid <= 1'b0;
      while (expected_terms.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/core/rtbmp_pkg.sv
rtl/core/rtbmp_modmul.sv
rtl/core/recurrence_term_by_matrix_power.sv
dv/tb_recurrence_term_by_matrix_power.sv
